>>> hw/rtl/tcc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcc_pkg: shared widths and types for the triangle circumcenter pipeline
// Datapath widths are sized to the worst case of signed Q8.8 corner inputs.
// ----------------------------------------------------------------------------
package tcc_pkg;

	localparam int CW      = 16;         // corner coordinate, Q8.8
	localparam int DW      = CW + 1;     // edge vector component
	localparam int CRW     = 2 * DW + 1; // cross product component, signed
	localparam int DOTW    = 2 * DW + 1; // dot product, signed
	localparam int LW      = 2 * DW;     // squared edge length, unsigned
	localparam int SQW     = 68;         // squared cross component (< 2^66), sum < 2^68
	localparam int DENW    = SQW + 1;    // twice the squared cross length
	localparam int WW      = LW + DOTW;  // corner weight numerator, signed
	localparam int TW      = WW + CW;    // weighted coordinate term, signed
	localparam int SW      = TW + 1;     // sum of three terms, signed
	localparam int FRAC_SH = 8;          // Q8.8 -> Q16.16 scaling of the numerator
	localparam int NW      = SW - 1 + FRAC_SH; // numerator magnitude
	localparam int QW      = 32;         // quotient bits below the overflow limit
	localparam int RW      = DENW + QW;  // divider remainder / shifted divisor
	localparam int OW      = 32;         // output coordinate, Q16.16
	localparam int NSTG    = 41;         // pipeline depth

	typedef logic signed [CW-1:0] crd_t;

	typedef struct packed {
		logic signed [OW-1:0] x;
		logic signed [OW-1:0] y;
		logic signed [OW-1:0] z;
		logic                 degen;
	} res_t;

endpackage
`default_nettype wire

>>> hw/rtl/triangle_circumcenter_3d.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// triangle_circumcenter_3d: circumcenter of a 3-D triangle
//
// Request channel: tri_valid/tri_stall with corners a, b, c (signed Q8.8).
// Result channel: ctr_valid/ctr_stall with center_x/y/z (signed Q16.16,
// rounded to nearest, ties away from zero, saturated) and degenerate, which
// is 1 with zero coordinates when the corners are collinear or coincide.
// A request is taken on a clock edge with valid high and stall low.
// A taken request passes through all 41 pipeline stages before its result
// is presented. One request per cycle is taken while tri_stall is low; the
// pipeline holds 32 quotient stages, each retiring one bit per coordinate.
// The receiver may stall at any time: a two-entry output (last stage plus
// a skid register) lets one more request in, after which tri_stall rises
// (it is a register, no path from ctr_stall). Nothing is lost or repeated.
// Reset (arst_n low) empties the pipeline; no request is in flight after.
// ----------------------------------------------------------------------------
module triangle_circumcenter_3d (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       tri_valid,
	output logic                       tri_stall,
	input  logic signed [tcc_pkg::CW-1:0] ax,
	input  logic signed [tcc_pkg::CW-1:0] ay,
	input  logic signed [tcc_pkg::CW-1:0] az,
	input  logic signed [tcc_pkg::CW-1:0] bx,
	input  logic signed [tcc_pkg::CW-1:0] by,
	input  logic signed [tcc_pkg::CW-1:0] bz,
	input  logic signed [tcc_pkg::CW-1:0] cx,
	input  logic signed [tcc_pkg::CW-1:0] cy,
	input  logic signed [tcc_pkg::CW-1:0] cz,
	output logic                       ctr_valid,
	input  logic                       ctr_stall,
	output logic signed [tcc_pkg::OW-1:0] center_x,
	output logic signed [tcc_pkg::OW-1:0] center_y,
	output logic signed [tcc_pkg::OW-1:0] center_z,
	output logic                       degenerate
);
	import tcc_pkg::*;

	function automatic logic signed [DOTW-1:0] dot3(
		input logic signed [DW-1:0] p [3],
		input logic signed [DW-1:0] q [3]
	);
		return DOTW'(p[0] * q[0]) + DOTW'(p[1] * q[1]) + DOTW'(p[2] * q[2]);
	endfunction

	// Corners as [corner][axis]
	crd_t crn_in [3][3];
	assign crn_in[0][0] = ax;
	assign crn_in[0][1] = ay;
	assign crn_in[0][2] = az;
	assign crn_in[1][0] = bx;
	assign crn_in[1][1] = by;
	assign crn_in[1][2] = bz;
	assign crn_in[2][0] = cx;
	assign crn_in[2][1] = cy;
	assign crn_in[2][2] = cz;

	// Flow control: pipeline moves while the skid register is empty
	logic             skid_full_q;
	logic             adv;
	logic [NSTG:1]    vld_q;
	res_t             res_s41;
	res_t             skid_q;

	assign adv       = ~skid_full_q;
	assign tri_stall = skid_full_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[NSTG-1:1], tri_valid};
		end
	end

	// Stage 1: register corners, edge vectors
	crd_t                 crn_s1 [3][3];
	logic signed [DW-1:0] ab_s1 [3];
	logic signed [DW-1:0] ac_s1 [3];
	logic signed [DW-1:0] bc_s1 [3];

	always_ff @(posedge clk) begin
		if (adv) begin
			crn_s1 <= crn_in;
			for (int k = 0; k < 3; k++) begin
				ab_s1[k] <= DW'(crn_in[0][k]) - DW'(crn_in[1][k]);
				ac_s1[k] <= DW'(crn_in[0][k]) - DW'(crn_in[2][k]);
				bc_s1[k] <= DW'(crn_in[1][k]) - DW'(crn_in[2][k]);
			end
		end
	end

	// Stage 2: cross product (a-b) x (b-c), squared edges, corner dots
	crd_t                   crn_s2 [3][3];
	logic signed [CRW-1:0]  cr_s2 [3];
	logic [LW-1:0]          len_s2 [3];
	logic signed [DOTW-1:0] dd_s2 [3];

	always_ff @(posedge clk) begin
		if (adv) begin
			crn_s2    <= crn_s1;
			cr_s2[0]  <= CRW'(ab_s1[1] * bc_s1[2]) - CRW'(ab_s1[2] * bc_s1[1]);
			cr_s2[1]  <= CRW'(ab_s1[2] * bc_s1[0]) - CRW'(ab_s1[0] * bc_s1[2]);
			cr_s2[2]  <= CRW'(ab_s1[0] * bc_s1[1]) - CRW'(ab_s1[1] * bc_s1[0]);
			len_s2[0] <= LW'(dot3(bc_s1, bc_s1));
			len_s2[1] <= LW'(dot3(ac_s1, ac_s1));
			len_s2[2] <= LW'(dot3(ab_s1, ab_s1));
			dd_s2[0]  <= dot3(ab_s1, ac_s1);
			dd_s2[1]  <= -dot3(ab_s1, bc_s1);
			dd_s2[2]  <= dot3(ac_s1, bc_s1);
		end
	end

	// Stage 3: squared cross components, corner weights
	crd_t                 crn_s3 [3][3];
	logic [SQW-1:0]       sq_s3 [3];
	logic signed [WW-1:0] w_s3 [3];

	always_ff @(posedge clk) begin
		if (adv) begin
			crn_s3 <= crn_s2;
			for (int k = 0; k < 3; k++) begin
				sq_s3[k] <= SQW'(cr_s2[k] * cr_s2[k]);
				w_s3[k]  <= WW'($signed({1'b0, len_s2[k]}) * dd_s2[k]);
			end
		end
	end

	// Stage 4: divisor, weighted corner terms
	logic [DENW-1:0]      den_s4;
	logic signed [TW-1:0] t_s4 [3][3];

	always_ff @(posedge clk) begin
		if (adv) begin
			den_s4 <= {sq_s3[0] + sq_s3[1] + sq_s3[2], 1'b0};
			for (int j = 0; j < 3; j++) begin
				for (int k = 0; k < 3; k++) begin
					t_s4[j][k] <= TW'(w_s3[j] * crn_s3[j][k]);
				end
			end
		end
	end

	// Stage 5: numerators, degenerate detect
	logic [DENW-1:0]      den_s5;
	logic                 degen_s5;
	logic signed [SW-1:0] s_s5 [3];

	always_ff @(posedge clk) begin
		if (adv) begin
			den_s5   <= den_s4;
			degen_s5 <= (den_s4 == '0);
			for (int k = 0; k < 3; k++) begin
				s_s5[k] <= SW'(t_s4[0][k]) + SW'(t_s4[1][k]) + SW'(t_s4[2][k]);
			end
		end
	end

	// Stage 6: sign and scaled magnitude of the numerators
	logic [DENW-1:0] den_s6;
	logic            degen_s6;
	logic            neg_s6 [3];
	logic [NW-1:0]   n_s6 [3];
	logic [SW-1:0]   mag_c [3];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			mag_c[k] = s_s5[k][SW-1] ? SW'(-s_s5[k]) : SW'(s_s5[k]);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			den_s6   <= den_s5;
			degen_s6 <= degen_s5;
			for (int k = 0; k < 3; k++) begin
				neg_s6[k] <= s_s5[k][SW-1];
				n_s6[k]   <= {mag_c[k][SW-2:0], FRAC_SH'(0)};
			end
		end
	end

	// Divider chain: index 0 is stage 7 (overflow check), index j retires
	// quotient bit QW-j; index QW is stage 39.
	logic [RW-1:0]   rem_sd [QW+1][3];
	logic [QW-1:0]   quo_sd [QW+1][3];
	logic            neg_sd [QW+1][3];
	logic            ovf_sd [QW+1][3];
	logic [DENW-1:0] den_sd [QW+1];
	logic            degen_sd [QW+1];

	always_ff @(posedge clk) begin
		if (adv) begin
			den_sd[0]   <= den_s6;
			degen_sd[0] <= degen_s6;
			for (int k = 0; k < 3; k++) begin
				rem_sd[0][k] <= RW'(n_s6[k]);
				quo_sd[0][k] <= '0;
				neg_sd[0][k] <= neg_s6[k];
				ovf_sd[0][k] <= RW'(n_s6[k]) >= {den_s6, QW'(0)};
			end
		end
	end

	for (genvar j = 1; j <= QW; j++) begin : g_div
		localparam int SH = QW - j;
		logic [RW-1:0] dsh;

		assign dsh = RW'(den_sd[j-1]) << SH;

		// one restoring step per coordinate
		always_ff @(posedge clk) begin
			if (adv) begin
				den_sd[j]   <= den_sd[j-1];
				degen_sd[j] <= degen_sd[j-1];
				for (int k = 0; k < 3; k++) begin
					neg_sd[j][k] <= neg_sd[j-1][k];
					ovf_sd[j][k] <= ovf_sd[j-1][k];
					if (rem_sd[j-1][k] >= dsh) begin
						rem_sd[j][k] <= rem_sd[j-1][k] - dsh;
						quo_sd[j][k] <= quo_sd[j-1][k] | (QW'(1) << SH);
					end else begin
						rem_sd[j][k] <= rem_sd[j-1][k];
						quo_sd[j][k] <= quo_sd[j-1][k];
					end
				end
			end
		end
	end

	// Stage 40: round half away from zero on the magnitude
	logic [QW:0] qr_s40 [3];
	logic        neg_s40 [3];
	logic        ovf_s40 [3];
	logic        degen_s40;

	always_ff @(posedge clk) begin
		if (adv) begin
			degen_s40 <= degen_sd[QW];
			for (int k = 0; k < 3; k++) begin
				neg_s40[k] <= neg_sd[QW][k];
				ovf_s40[k] <= ovf_sd[QW][k];
				qr_s40[k]  <= {1'b0, quo_sd[QW][k]} +
					(QW+1)'({rem_sd[QW][k][DENW-1:0], 1'b0} >= {1'b0, den_sd[QW]});
			end
		end
	end

	// Stage 41: saturate, apply sign, force zero when degenerate
	logic [QW:0]   lim_c [3];
	logic [QW:0]   sat_c [3];
	logic [OW-1:0] val_c [3];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			lim_c[k] = {2'b0, {(QW-1){1'b1}}} + (QW+1)'(neg_s40[k]);
			sat_c[k] = (ovf_s40[k] || qr_s40[k] > lim_c[k]) ? lim_c[k] : qr_s40[k];
			if (degen_s40) begin
				val_c[k] = '0;
			end else if (neg_s40[k]) begin
				val_c[k] = -sat_c[k][OW-1:0];
			end else begin
				val_c[k] = sat_c[k][OW-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s41.x     <= val_c[0];
			res_s41.y     <= val_c[1];
			res_s41.z     <= val_c[2];
			res_s41.degen <= degen_s40;
		end
	end

	// Skid register catches the last stage when the receiver stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_full_q <= 1'b0;
		end else if (skid_full_q) begin
			if (!ctr_stall) skid_full_q <= 1'b0;
		end else if (vld_q[NSTG] && ctr_stall) begin
			skid_full_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!skid_full_q) skid_q <= res_s41;
	end

	// Result port: skid entry is older than the last stage
	assign ctr_valid  = skid_full_q | vld_q[NSTG];
	assign center_x   = skid_full_q ? skid_q.x     : res_s41.x;
	assign center_y   = skid_full_q ? skid_q.y     : res_s41.y;
	assign center_z   = skid_full_q ? skid_q.z     : res_s41.z;
	assign degenerate = skid_full_q ? skid_q.degen : res_s41.degen;

endmodule
`default_nettype wire

>>> hw/rtl/tcc_chk.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcc_chk: port-level checks for the circumcenter pipeline
// Watches the request and result channels of the top level.
// ----------------------------------------------------------------------------
module tcc_chk (
	input wire                         clk,
	input wire                         arst_n,
	input wire                         tri_valid,
	input wire                         tri_stall,
	input wire                         ctr_valid,
	input wire                         ctr_stall,
	input wire signed [tcc_pkg::OW-1:0] center_x,
	input wire signed [tcc_pkg::OW-1:0] center_y,
	input wire signed [tcc_pkg::OW-1:0] center_z,
	input wire                         degenerate
);
	import tcc_pkg::*;

	// a stalled result keeps its payload
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		ctr_valid && ctr_stall |=> ctr_valid && $stable(center_x) &&
		$stable(center_y) && $stable(center_z) && $stable(degenerate))
		else $error("result changed while stalled");

	// degenerate triangles report a zero center
	a_degen: assert property (@(posedge clk) disable iff (!arst_n)
		ctr_valid && degenerate |-> center_x == '0 && center_y == '0 &&
		center_z == '0)
		else $error("degenerate result with nonzero center");

	// request stall only while a result is held back
	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		tri_stall |-> ctr_valid)
		else $error("request stall without a pending result");

	// request stall rises only after a stalled result
	a_stall_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(tri_stall) |-> $past(ctr_valid && ctr_stall))
		else $error("request stall rose without a receiver stall");

	// after a stalled request, a stall that stays up while the receiver did not stall still has a valid result
	a_no_accept: assert property (@(posedge clk) disable iff (!arst_n)
		tri_valid && tri_stall |=> $past(ctr_stall) || !tri_stall || ctr_valid)
		else $error("request stall state inconsistent");

endmodule

bind triangle_circumcenter_3d tcc_chk u_tcc_chk (.*);
`default_nettype wire
